// ----- hw/rtl/aiwd_pkg.sv -----
`default_nettype none
package aiwd_pkg;

   // Operation codes carried in req_tuser
   typedef logic [2:0] op_type;
   localparam op_type OP_TICK   = 3'd0;
   localparam op_type OP_REMOTE = 3'd1;
   localparam op_type OP_WRENCH = 3'd2;
   localparam op_type OP_OTHER  = 3'd3;
   localparam op_type OP_READY  = 3'd4;

   // Configuration register indexes
   typedef logic [1:0] csr_idx_type;
   localparam csr_idx_type CSR_TIMEOUT = 2'd0;
   localparam csr_idx_type CSR_FORCE   = 2'd1;
   localparam csr_idx_type CSR_TORQUE  = 2'd2;

   // Register reset values
   localparam logic [15:0] TIMEOUT_RST = 16'd50;
   localparam logic [14:0] FORCE_RST   = 15'd256;
   localparam logic [14:0] TORQUE_RST  = 15'd256;

   // Fixed topics of the remote and wrench frames
   localparam logic [2:0] TOPIC_REMOTE = 3'd0;
   localparam logic [2:0] TOPIC_WRENCH = 3'd3;

   // Watchdog counter codes
   localparam int          CNT_W     = 17;
   localparam logic [16:0] CNT_NEVER = 17'h1FFFF;
   localparam logic [16:0] CNT_MAX   = 17'h1FFFE;

   // Defaults of the top level parameters
   localparam int NUM_TOPICS_DEF = 8;
   localparam int STICK_BITS_DEF = 12;

   // Number of values in a remote or wrench frame
   localparam int NUM_VALS = 6;

   typedef logic signed [15:0] word_type;

   // Decoded event of one beat, shared by the watchdog bank and arming logic
   typedef struct packed {
      logic       fire;       // item leaves the input register this cycle
      logic       tick;
      logic       remote;
      logic       wrench;
      logic       heartbeat;  // any counted heartbeat
      logic [2:0] topic;      // topic of that heartbeat
   } evt_type;

endpackage
`default_nettype wire

// ----- hw/rtl/aiwd_watchdog.sv -----
`default_nettype none
module aiwd_watchdog
   import aiwd_pkg::*;
#(
   parameter int NUM_TOPICS = NUM_TOPICS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire evt_type               evt,
   input  wire logic                  ready_flag,
   input  wire logic [15:0]           timeout_ticks,
   output logic      [NUM_TOPICS-1:0] present_next,
   output logic      [NUM_TOPICS-1:0] timed_out,
   output logic      [NUM_TOPICS-1:0] resumed
);

   logic [CNT_W-1:0]      cnt_ff [NUM_TOPICS];
   logic [CNT_W-1:0]      cnt_in [NUM_TOPICS];
   logic [NUM_TOPICS-1:0] present_ff;
   logic [CNT_W-1:0]      eff_to;
   logic                  adv;

   // Timeout below two acts as two
   assign eff_to = (timeout_ticks < 16'd2) ? 17'd2 : {1'b0, timeout_ticks};
   assign adv    = evt.fire && evt.tick && ready_flag;

   // One counter per topic, all updated in parallel
   for (genvar i = 0; i < NUM_TOPICS; i++) begin : g_topic
      logic             hit;
      logic [CNT_W-1:0] inc;

      assign hit = evt.fire && evt.heartbeat && (5'(evt.topic) == 5'(i));
      assign inc = (cnt_ff[i] < CNT_MAX) ? cnt_ff[i] + 17'd1 : cnt_ff[i];

      always_comb begin
         cnt_in[i]       = cnt_ff[i];
         present_next[i] = present_ff[i];
         timed_out[i]    = 1'b0;
         resumed[i]      = 1'b0;
         if (hit) begin
            cnt_in[i]       = '0;
            present_next[i] = 1'b1;
            resumed[i]      = (cnt_ff[i] != CNT_NEVER) && (cnt_ff[i] > eff_to);
         end else if (adv && (cnt_ff[i] != CNT_NEVER)) begin
            cnt_in[i] = inc;
            if (inc == eff_to) begin
               present_next[i] = 1'b0;
               timed_out[i]    = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cnt_ff[i] <= CNT_NEVER;
         end else begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
      end else begin
         present_ff <= present_next;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/aiwd_arming.sv -----
`default_nettype none
module aiwd_arming
   import aiwd_pkg::*;
#(
   parameter int STICK_BITS = STICK_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire evt_type     evt,
   input  wire logic        ready_flag,
   input  wire logic [11:0] arm_level,
   input  wire word_type    vals [NUM_VALS],
   input  wire logic [14:0] force_limit,
   input  wire logic [14:0] torque_limit,
   output logic             armed_next,
   output logic             reject_next
);

   // Full scale and the stick thresholds scaled by 20
   localparam logic [17:0]        FS    = 18'((1 << STICK_BITS) - 1);
   localparam logic signed [23:0] C_LO  = 24'(9 * ((1 << STICK_BITS) - 1));
   localparam logic signed [23:0] C_HI  = 24'(11 * ((1 << STICK_BITS) - 1));
   localparam logic signed [23:0] C_THR = 24'((1 << STICK_BITS) - 1);

   word_type wrench_ff [NUM_VALS];
   logic     armed_ff;
   logic     reject_ff;

   logic [NUM_VALS-1:0] stick_pass;
   logic [NUM_VALS-1:0] wr_pass;
   logic                switch_hi;

   // Stick checks: 20 v compared against 9, 11 or 1 times full scale
   for (genvar i = 0; i < NUM_VALS; i++) begin : g_val
      logic signed [23:0] ext;
      logic signed [23:0] x20;
      logic signed [16:0] wext;
      logic        [14:0] lim;

      assign ext = {{8{vals[i][15]}}, vals[i]};
      assign x20 = (ext <<< 4) + (ext <<< 2);

      if (i == 2) begin : g_thr
         assign stick_pass[i] = x20 < C_THR;
      end else begin : g_ctr
         assign stick_pass[i] = (x20 > C_LO) && (x20 < C_HI);
      end

      // Wrench checks on the stored setpoint; force z is compared signed
      assign wext = {wrench_ff[i][15], wrench_ff[i]};
      assign lim  = (i < 3) ? force_limit : torque_limit;

      if (i == 2) begin : g_fz
         assign wr_pass[i] = wext < $signed({2'b00, lim});
      end else begin : g_abs
         logic signed [16:0] mag;

         assign mag        = wext[16] ? -wext : wext;
         assign wr_pass[i] = $unsigned(mag) < {2'b00, lim};
      end
   end

   assign switch_hi = {5'b0, arm_level, 1'b0} > FS;

   // Arm, reject or disarm on remote frames
   always_comb begin
      armed_next  = armed_ff;
      reject_next = reject_ff;
      if (evt.fire && evt.remote) begin
         if (!ready_flag) begin
            armed_next = 1'b0;
         end else if (switch_hi) begin
            if (!armed_ff && !reject_ff) begin
               if ((&stick_pass) && (&wr_pass)) begin
                  armed_next = 1'b1;
               end else begin
                  reject_next = 1'b1;
               end
            end
         end else begin
            armed_next  = 1'b0;
            reject_next = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff  <= 1'b0;
         reject_ff <= 1'b0;
      end else begin
         armed_ff  <= armed_next;
         reject_ff <= reject_next;
      end
   end

   // Wrench setpoint store
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_VALS; i++) begin
            wrench_ff[i] <= '0;
         end
      end else if (evt.fire && evt.wrench) begin
         for (int i = 0; i < NUM_VALS; i++) begin
            wrench_ff[i] <= vals[i];
         end
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/arming_interlock_with_link_watchdogs.sv -----
// Arming interlock with link watchdogs.
// Input beats (req_*) carry one event: the operation code in req_tuser
// (tick, remote frame, wrench frame, other heartbeat, declare ready) and
// the frame payload in req_tdata. Each beat produces exactly one result
// beat (rsp_*) with the present flags, arming state, ready state and the
// per-topic timeout / resumption strobes of that event.
// Registers (timeout, force limit, torque limit) are written on the csr_*
// channel, which is always ready; write them only while the block is idle.
// A beat accepted into the input register has its result loaded into the
// output register once that register is free, and rsp_tvalid then rises.
// Throughput is one beat per cycle while the receiver takes results: all
// watchdog counters and the arming checks are evaluated in one pass between
// the input and output registers.
// When the receiver stalls, the result holds in the output register, and one
// more beat can still be taken into the input register; req_tready then drops.
// Synchronous reset clears the counters to never seen, the present bits,
// armed, reject and ready flags, the stored wrench and loads register defaults.
`default_nettype none
module arming_interlock_with_link_watchdogs
   import aiwd_pkg::*;
#(
   parameter int NUM_TOPICS = NUM_TOPICS_DEF,
   parameter int STICK_BITS = STICK_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // req_tdata, lowest bit up: topic_id[3], hw_fault[1], arm_level[12],
   // val_x_or_force_x, val_y_or_force_y, val_z_or_force_z,
   // val_yaw_or_torque_x, val_pitch_or_torque_y, val_roll_or_torque_z [16 each]
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [111:0] req_tdata,
   input  wire logic [2:0]   req_tuser,   // operation[3]
   // rsp_tdata, lowest bit up: present_flags[8], armed_state[1],
   // arm_rejected[1], ready_state[1], timed_out_now[8], resumed_now[8], zeros[5]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [31:0]       rsp_tdata,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [15:0]  csr_data
);

   // Input register
   logic        in_valid_ff;
   op_type      op_ff;
   logic [2:0]  topic_ff;
   logic        fault_ff;
   logic [11:0] level_ff;
   word_type    vals_ff [NUM_VALS];

   // Output register
   logic        out_valid_ff;
   logic [26:0] out_ff;
   logic [26:0] out_in;

   // Configuration and ready flag
   logic [15:0] timeout_ff;
   logic [14:0] force_ff;
   logic [14:0] torque_ff;
   logic        ready_ff;
   logic        ready_in;

   logic        advance;
   evt_type     evt;

   logic [NUM_TOPICS-1:0] present_next;
   logic [NUM_TOPICS-1:0] timed_out;
   logic [NUM_TOPICS-1:0] resumed;
   logic [7:0]            present8;
   logic [7:0]            timed8;
   logic [7:0]            resumed8;
   logic                  armed_next;
   logic                  reject_next;

   // Handshake: the input stage moves on when the output register is free
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, out_ff};
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff    <= req_tuser;
         topic_ff <= req_tdata[2:0];
         fault_ff <= req_tdata[3];
         level_ff <= req_tdata[15:4];
         for (int i = 0; i < NUM_VALS; i++) begin
            vals_ff[i] <= req_tdata[16 + 16*i +: 16];
         end
      end
   end

   // Operation decode
   always_comb begin
      evt           = '0;
      evt.fire      = advance;
      evt.topic     = topic_ff;
      ready_in      = ready_ff;
      unique case (op_ff)
         OP_TICK: begin
            evt.tick = 1'b1;
         end
         OP_REMOTE: begin
            evt.remote    = 1'b1;
            evt.heartbeat = 1'b1;
            evt.topic     = TOPIC_REMOTE;
         end
         OP_WRENCH: begin
            evt.wrench    = 1'b1;
            evt.heartbeat = 1'b1;
            evt.topic     = TOPIC_WRENCH;
         end
         OP_OTHER: begin
            evt.heartbeat = !fault_ff;
         end
         OP_READY: begin
            ready_in = ready_ff || advance;
         end
         default: begin
         end
      endcase
   end

   aiwd_watchdog #(
      .NUM_TOPICS (NUM_TOPICS)
   ) u_watchdog (
      .clock         (clock),
      .reset         (reset),
      .evt           (evt),
      .ready_flag    (ready_ff),
      .timeout_ticks (timeout_ff),
      .present_next  (present_next),
      .timed_out     (timed_out),
      .resumed       (resumed)
   );

   aiwd_arming #(
      .STICK_BITS (STICK_BITS)
   ) u_arming (
      .clock        (clock),
      .reset        (reset),
      .evt          (evt),
      .ready_flag   (ready_ff),
      .arm_level    (level_ff),
      .vals         (vals_ff),
      .force_limit  (force_ff),
      .torque_limit (torque_ff),
      .armed_next   (armed_next),
      .reject_next  (reject_next)
   );

   // Map the topic vectors onto the 8-bit result fields
   for (genvar b = 0; b < 8; b++) begin : g_out
      if (b < NUM_TOPICS) begin : g_have
         assign present8[b] = present_next[b];
         assign timed8[b]   = timed_out[b];
         assign resumed8[b] = resumed[b];
      end else begin : g_none
         assign present8[b] = 1'b0;
         assign timed8[b]   = 1'b0;
         assign resumed8[b] = 1'b0;
      end
   end

   assign out_in = {resumed8, timed8, ready_in, reject_next, armed_next, present8};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         ready_ff     <= 1'b0;
      end else begin
         ready_ff <= ready_in;
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RST;
         force_ff   <= FORCE_RST;
         torque_ff  <= TORQUE_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TIMEOUT: timeout_ff <= csr_data;
            CSR_FORCE:   force_ff   <= csr_data[14:0];
            CSR_TORQUE:  torque_ff  <= csr_data[14:0];
            default: begin
            end
         endcase
      end
   end

   // Armed and rejected are never reported together
   a_arm_excl: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_ff[8] && out_ff[9]))
      else $error("armed and rejected both set");

   // Armed implies the supervisor was declared ready
   a_arm_ready: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff[8] |-> out_ff[10])
      else $error("armed while not ready");

   // A result never reports a timeout and a resumption at once
   a_strobe_excl: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff[18:11] == 8'd0) || (out_ff[26:19] == 8'd0))
      else $error("timeout and resume in one result");

   // Ready is sticky until reset
   a_ready_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(ready_ff) && !$past(reset) |-> ready_ff)
      else $error("ready flag dropped");

endmodule
`default_nettype wire
